[rtl/lurt_pkg.sv]
`default_nettype none

package lurt_pkg;

  localparam int SYM_W   = 8;
  localparam int POS_W   = 17;
  localparam int DEPTH   = 1 << SYM_W;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 24;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t MAX_LEN = pos_t'(65536);

  typedef struct packed {
    logic en;
    logic clr;
    sym_t addr;
    pos_t pos;
  } wr_req_t;

endpackage

`default_nettype wire

[rtl/lurt_pos_table.sv]
`default_nettype none

module lurt_pos_table (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    rd_en,
  input  wire lurt_pkg::sym_t    rd_addr,
  output lurt_pkg::pos_t         rd_data,
  input  wire lurt_pkg::sym_t    seen_addr,
  output logic                   seen_hit,
  input  wire lurt_pkg::wr_req_t wr
);
  import lurt_pkg::*;

  pos_t             pos_mem_r [DEPTH];
  pos_t             rd_data_r;
  logic [DEPTH-1:0] seen_r;
  logic [DEPTH-1:0] seen_nxt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      pos_mem_r[wr.addr] <= wr.pos;
    end
    if (rd_en) begin
      rd_data_r <= pos_mem_r[rd_addr];
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    if (wr.en) begin
      seen_nxt[wr.addr] = 1'b1;
    end
    if (wr.clr) begin
      seen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  assign rd_data  = rd_data_r;
  assign seen_hit = seen_r[seen_addr];

endmodule

`default_nettype wire

[rtl/longest_unique_run_tracker.sv]
`default_nettype none

// Channel  Dir  Bus      Beat contents
// in_      in   tdata    [7:0] symbol; tlast = final_symbol
// out_     out  tdata    [16:0] best_length, [23:17] zero; tlast = string_done;
//                        tuser = overflow
//
// One beat per cycle while the output is not stalled; the table is read when a beat is
// accepted, and the update stage then writes the output register. The read-modify-write
// of the last-position table forwards the position written in the same cycle as the read.
// Reset is synchronous; no clearing pass: seen bits are flops cleared at string close.
// A stalled output holds the update stage; the input stalls only behind it.

module longest_unique_run_tracker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] symbol
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [16:0] best_length, [23:17] zero
  output logic        out_tlast,
  output logic        out_tuser   // [0] overflow
);
  import lurt_pkg::*;

  logic    in_acc;
  logic    s1_adv;
  logic    sat;
  logic    seen_hit;
  pos_t    rd_data;
  pos_t    last_pos;
  pos_t    win_step;
  pos_t    run;
  pos_t    best_step;
  logic    ovf_step;
  wr_req_t wr;

  logic s1_valid_r, s1_valid_nxt;
  sym_t s1_sym_r;
  logic s1_fin_r;
  logic s1_fwd_r;
  pos_t s1_fwd_pos_r;

  pos_t pos_cnt_r, pos_cnt_nxt;
  pos_t win_r, win_nxt;
  pos_t best_r, best_nxt;
  logic ovf_r, ovf_nxt;

  logic out_valid_r, out_valid_nxt;
  pos_t out_best_r;
  logic out_done_r;
  logic out_ovf_r;

  assign s1_adv    = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_adv;
  assign in_acc    = in_tvalid & in_tready;
  assign sat       = (pos_cnt_r >= MAX_LEN);

  assign wr.en   = s1_adv & ~sat;
  assign wr.clr  = s1_adv & s1_fin_r;
  assign wr.addr = s1_sym_r;
  assign wr.pos  = pos_cnt_r;

  lurt_pos_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_addr   (in_tdata[SYM_W-1:0]),
    .rd_data   (rd_data),
    .seen_addr (s1_sym_r),
    .seen_hit  (seen_hit),
    .wr        (wr)
  );

  always_comb begin
    last_pos  = s1_fwd_r ? s1_fwd_pos_r : rd_data;
    win_step  = win_r;
    if (seen_hit && (last_pos >= win_r)) begin
      win_step = last_pos + pos_t'(1);
    end
    run       = pos_cnt_r - win_step + pos_t'(1);
    best_step = best_r;
    if (!sat && (run > best_r)) begin
      best_step = run;
    end
    ovf_step  = ovf_r | sat;
  end

  always_comb begin
    pos_cnt_nxt = pos_cnt_r;
    win_nxt     = win_r;
    best_nxt    = best_r;
    ovf_nxt     = ovf_r;
    if (s1_adv) begin
      if (s1_fin_r) begin
        pos_cnt_nxt = '0;
        win_nxt     = '0;
        best_nxt    = '0;
        ovf_nxt     = 1'b0;
      end else begin
        if (!sat) begin
          pos_cnt_nxt = pos_cnt_r + pos_t'(1);
          win_nxt     = win_step;
        end
        best_nxt = best_step;
        ovf_nxt  = ovf_step;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_cnt_r   <= '0;
      win_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_cnt_r   <= pos_cnt_nxt;
      win_r       <= win_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // capture the beat; flag a same-cycle write to its table entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sym_r     <= in_tdata[SYM_W-1:0];
      s1_fin_r     <= in_tlast;
      s1_fwd_r     <= wr.en & (s1_sym_r == in_tdata[SYM_W-1:0]);
      s1_fwd_pos_r <= pos_cnt_r;
    end
    if (s1_adv) begin
      out_best_r <= best_step;
      out_done_r <= s1_fin_r;
      out_ovf_r  <= ovf_step;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_OUT_W-POS_W){1'b0}}, out_best_r};
  assign out_tlast  = out_done_r;
  assign out_tuser  = out_ovf_r;

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_fin_r) |=> (pos_cnt_r == '0 && best_r == '0 && !ovf_r))
    else $error("string close did not clear counters");

  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    (win_r <= pos_cnt_r))
    else $error("window start beyond position count");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (best_r <= pos_cnt_r))
    else $error("best length exceeds position count");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (pos_cnt_r == MAX_LEN))
    else $error("overflow set below saturation");

endmodule

`default_nettype wire
